// ----- sv/cmee_pkg.sv -----
// ----------------------------------------------------------------------------
// cmee_pkg - shared types and constants of the context model entropy estimator
// Widths of the word fields, count limits and the control structures that pass
// between the sequencer and the probability unit.
// ----------------------------------------------------------------------------
package cmee_pkg;

    localparam int CONTEXT_BITS_W     = 5;
    localparam int CONTEXT_BITS_RESET = 16;
    localparam int MAX_CONTEXT_BITS_DEF = 16;
    localparam int PROB_FRAC_BITS_DEF   = 32;

    localparam int COUNT_W      = 15;
    localparam int TOTAL_W      = 16;
    localparam int COUNT_LIMIT  = 16384;
    localparam int ENTROPY_W    = 24;
    localparam int SAMPLE_W     = 17;
    localparam int WINDOW_LIMIT = 80000;
    localparam int IN_TDATA_W   = 8;
    localparam int OUT_TDATA_W  = 48;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_CALC,
        S_WRITE,
        S_EMIT,
        S_HALVE
    } t_state;

    typedef enum logic [1:0] {
        P_IDLE,
        P_MUL,
        P_DIV,
        P_NORM
    } t_prob_state;

    typedef struct packed {
        logic               start;
        logic               skip;
        logic [COUNT_W-1:0] count;
        logic [TOTAL_W-1:0] total;
    } t_prob_req;

    typedef struct packed {
        logic dbl;
        logic done;
    } t_prob_stat;

endpackage

// ----- sv/cmee_ram.sv -----
// ----------------------------------------------------------------------------
// cmee_ram - generic simple dual-port RAM
// One write port and one read port, with the read data registered.
// ----------------------------------------------------------------------------
module cmee_ram #(
    parameter int WIDTH = 2 * cmee_pkg::COUNT_W,
    parameter int DEPTH = 1 << cmee_pkg::MAX_CONTEXT_BITS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/cmee_prob.sv -----
// ----------------------------------------------------------------------------
// cmee_prob - bit-serial probability unit
// Holds the running probability, multiplies it by a count one bit per cycle,
// divides by the context total one quotient bit per cycle and renormalises it
// one doubling per cycle, flagging each doubling.
// ----------------------------------------------------------------------------
module cmee_prob #(
    parameter int PROB_FRAC_BITS = cmee_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  cmee_pkg::t_prob_req  i_req,
    output cmee_pkg::t_prob_stat o_stat
);

    localparam int PW = PROB_FRAC_BITS + 1;
    localparam int CW = cmee_pkg::COUNT_W;
    localparam int TW = cmee_pkg::TOTAL_W;
    localparam int AW = PW + CW;
    localparam int NW = $clog2(PW + 1);
    localparam logic [PW-1:0] PROB_ONE  = PW'(1) << PROB_FRAC_BITS;
    localparam logic [PW-1:0] PROB_HALF = PW'(1) << (PROB_FRAC_BITS - 1);

    cmee_pkg::t_prob_state r_state, n_state;
    logic [PW-1:0] r_prob, n_prob;
    logic [AW-1:0] r_acc, n_acc;
    logic [CW-1:0] r_mult, n_mult;
    logic [TW-1:0] r_total, n_total;
    logic [TW-1:0] r_rem, n_rem;
    logic [NW-1:0] r_cnt, n_cnt;
    logic [TW:0]   trial;
    logic          ge;
    logic          above_half;

    assign above_half = (r_prob > PROB_HALF);
    assign trial      = {r_rem, r_acc[PW-1]};
    assign ge         = (trial >= {1'b0, r_total});

    always_comb begin
        n_state = r_state;
        case (r_state)
            cmee_pkg::P_IDLE: begin
                if (i_req.start) begin
                    n_state = i_req.skip ? cmee_pkg::P_NORM : cmee_pkg::P_MUL;
                end
            end
            cmee_pkg::P_MUL: begin
                if (r_cnt == '0) begin
                    n_state = cmee_pkg::P_DIV;
                end
            end
            cmee_pkg::P_DIV: begin
                if (r_cnt == '0) begin
                    n_state = cmee_pkg::P_NORM;
                end
            end
            cmee_pkg::P_NORM: begin
                if (above_half) begin
                    n_state = cmee_pkg::P_IDLE;
                end
            end
            default: n_state = cmee_pkg::P_IDLE;
        endcase
    end

    always_comb begin
        o_stat.dbl  = (r_state == cmee_pkg::P_NORM) && (r_prob != '0) && !above_half;
        o_stat.done = (r_state == cmee_pkg::P_NORM) && above_half;
    end

    always_comb begin
        n_prob  = r_prob;
        n_acc   = r_acc;
        n_mult  = r_mult;
        n_total = r_total;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        case (r_state)
            cmee_pkg::P_IDLE: begin
                if (i_req.start && !i_req.skip) begin
                    n_acc   = '0;
                    n_mult  = i_req.count;
                    n_total = i_req.total;
                    n_cnt   = NW'(CW - 1);
                end
            end
            cmee_pkg::P_MUL: begin
                n_acc  = (r_acc << 1) + (r_mult[CW-1] ? AW'(r_prob) : AW'(0));
                n_mult = r_mult << 1;
                if (r_cnt == '0) begin
                    n_rem = TW'(n_acc[AW-1:PW]);
                    n_cnt = NW'(PW - 1);
                end else begin
                    n_cnt = r_cnt - NW'(1);
                end
            end
            cmee_pkg::P_DIV: begin
                n_rem = ge ? TW'(trial - {1'b0, r_total}) : TW'(trial);
                n_acc[PW-1:0] = {r_acc[PW-2:0], ge};
                if (r_cnt == '0) begin
                    n_prob = {r_acc[PW-2:0], ge};
                end else begin
                    n_cnt = r_cnt - NW'(1);
                end
            end
            cmee_pkg::P_NORM: begin
                if (r_prob == '0) begin
                    n_prob = PW'(1);
                end else if (!above_half) begin
                    n_prob = r_prob << 1;
                end
            end
            default: begin
                n_prob = r_prob;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cmee_pkg::P_IDLE;
            r_prob  <= PROB_ONE;
        end else begin
            r_state <= n_state;
            r_prob  <= n_prob;
        end
        r_acc   <= n_acc;
        r_mult  <= n_mult;
        r_total <= n_total;
        r_rem   <= n_rem;
        r_cnt   <= n_cnt;
    end

endmodule

// ----- sv/context_model_entropy_estimator.sv -----
// ----------------------------------------------------------------------------
// context_model_entropy_estimator - Markov context model entropy estimator
// Predicts each noise bit from the preceding bits, keeps per-context counts
// and accumulates the entropy bit count and the sample count.
//
//   Channel   Direction  Word contents (lowest bit first)
//   s_axis    in         sample_bit, 7 bits of padding
//   m_axis    out        entropy_bits[23:0], samples_counted[16:0], padding
//   cfg       in         context_bits[4:0]
//
// Each word passes through fetch, a serial multiply, a bit-serial divide and
// renormalising doublings, then count write-back and emit; with a zero count
// the multiply and divide are skipped. A new word is taken only when idle.
// After reset a clearing pass zeroes the count memory; when a count reaches
// its limit a halving sweep of the whole memory follows. No word is taken
// during either. A finished word waits in the output register while the
// next is accepted.
// ----------------------------------------------------------------------------
module context_model_entropy_estimator #(
    parameter int MAX_CONTEXT_BITS = cmee_pkg::MAX_CONTEXT_BITS_DEF,
    parameter int PROB_FRAC_BITS   = cmee_pkg::PROB_FRAC_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // sample_bit
    input  logic [cmee_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // entropy_bits, samples_counted
    output logic [cmee_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [cmee_pkg::CONTEXT_BITS_W-1:0] i_cfg_data
);

    localparam int CBW   = cmee_pkg::CONTEXT_BITS_W;
    localparam int CW    = cmee_pkg::COUNT_W;
    localparam int TW    = cmee_pkg::TOTAL_W;
    localparam int EW    = cmee_pkg::ENTROPY_W;
    localparam int SW    = cmee_pkg::SAMPLE_W;
    localparam int HW    = MAX_CONTEXT_BITS;
    localparam int DEPTH = 1 << MAX_CONTEXT_BITS;
    localparam int IW    = MAX_CONTEXT_BITS + 1;
    localparam int RW    = 2 * CW;
    localparam logic [CBW-1:0] MAX_K     = CBW'(MAX_CONTEXT_BITS);
    localparam logic [EW-1:0]  ENT_MAX   = '1;
    localparam logic [CW-1:0]  CNT_LIMIT = CW'(cmee_pkg::COUNT_LIMIT);
    localparam logic [SW-1:0]  WIN_LIMIT = SW'(cmee_pkg::WINDOW_LIMIT);

    cmee_pkg::t_state     r_state, n_state;
    cmee_pkg::t_prob_req  prob_req;
    cmee_pkg::t_prob_stat prob_stat;

    logic [CBW-1:0] r_context_bits;
    logic [CBW-1:0] k_eff;
    logic [HW-1:0]  mask;
    logic [HW-1:0]  r_history;
    logic [HW-1:0]  hist_next;
    logic           r_last_bit;
    logic           r_bit;
    logic [IW-1:0]  r_idx;
    logic           r_halve;
    logic [RW-1:0]  r_word;
    logic [EW-1:0]  r_entropy;
    logic [SW-1:0]  r_samples;
    logic [SW-1:0]  samples_inc;
    logic           r_m_valid;
    logic [cmee_pkg::OUT_TDATA_W-1:0] r_m_tdata;

    logic           in_accept;
    logic           emit_load;
    logic [CW-1:0]  old_count;
    logic [CW-1:0]  new_count;
    logic           ram_we;
    logic [HW-1:0]  ram_waddr;
    logic [RW-1:0]  ram_wdata;
    logic [HW-1:0]  ram_raddr;
    logic [RW-1:0]  ram_rdata;
    logic [CW-1:0]  rd_ones;
    logic [CW-1:0]  rd_zeros;
    logic [HW-1:0]  idx_prev;

    assign in_accept = s_axis_tvalid && s_axis_tready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        if (r_context_bits == '0) begin
            k_eff = CBW'(1);
        end else if (r_context_bits > MAX_K) begin
            k_eff = MAX_K;
        end else begin
            k_eff = r_context_bits;
        end
        for (int j = 0; j < HW; j++) begin
            mask[j] = (CBW'(j) < k_eff);
        end
        hist_next = ((r_history << 1) | HW'(r_last_bit)) & mask;
    end

    assign rd_ones     = ram_rdata[RW-1:CW];
    assign rd_zeros    = ram_rdata[CW-1:0];
    assign old_count   = r_bit ? r_word[RW-1:CW] : r_word[CW-1:0];
    assign new_count   = old_count + CW'(1);
    assign samples_inc = r_samples + SW'(1);
    assign idx_prev    = HW'(r_idx - IW'(1));

    always_comb begin
        n_state = r_state;
        case (r_state)
            cmee_pkg::S_CLEAR: begin
                if (r_idx == IW'(DEPTH - 1)) begin
                    n_state = cmee_pkg::S_IDLE;
                end
            end
            cmee_pkg::S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_state = cmee_pkg::S_FETCH;
                end
            end
            cmee_pkg::S_FETCH: n_state = cmee_pkg::S_CALC;
            cmee_pkg::S_CALC: begin
                if (prob_stat.done) begin
                    n_state = cmee_pkg::S_WRITE;
                end
            end
            cmee_pkg::S_WRITE: n_state = cmee_pkg::S_EMIT;
            cmee_pkg::S_EMIT: begin
                if (!r_m_valid || m_axis_tready) begin
                    n_state = r_halve ? cmee_pkg::S_HALVE : cmee_pkg::S_IDLE;
                end
            end
            cmee_pkg::S_HALVE: begin
                if (r_idx == IW'(DEPTH)) begin
                    n_state = cmee_pkg::S_IDLE;
                end
            end
            default: n_state = cmee_pkg::S_CLEAR;
        endcase
    end

    always_comb begin
        s_axis_tready  = 1'b0;
        emit_load      = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = r_idx[HW-1:0];
        ram_wdata      = '0;
        ram_raddr      = hist_next;
        prob_req.start = 1'b0;
        prob_req.count = r_bit ? rd_ones : rd_zeros;
        prob_req.total = TW'(rd_ones) + TW'(rd_zeros);
        prob_req.skip  = (prob_req.count == '0) || (prob_req.total == '0);
        case (r_state)
            cmee_pkg::S_CLEAR: begin
                ram_we = 1'b1;
            end
            cmee_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            cmee_pkg::S_FETCH: begin
                prob_req.start = 1'b1;
            end
            cmee_pkg::S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_history;
                ram_wdata = r_bit ? {new_count, r_word[CW-1:0]}
                                  : {r_word[RW-1:CW], new_count};
            end
            cmee_pkg::S_EMIT: begin
                emit_load = !r_m_valid || m_axis_tready;
            end
            cmee_pkg::S_HALVE: begin
                ram_raddr = r_idx[HW-1:0];
                ram_we    = (r_idx != '0);
                ram_waddr = idx_prev;
                ram_wdata = {1'b0, rd_ones[CW-1:1], 1'b0, rd_zeros[CW-1:1]};
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= cmee_pkg::S_CLEAR;
            r_context_bits <= CBW'(cmee_pkg::CONTEXT_BITS_RESET);
            r_history      <= '0;
            r_last_bit     <= 1'b0;
            r_idx          <= '0;
            r_halve        <= 1'b0;
            r_entropy      <= '0;
            r_samples      <= '0;
            r_m_valid      <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_context_bits <= i_cfg_data;
            end
            if (in_accept) begin
                r_history  <= hist_next;
                r_last_bit <= s_axis_tdata[0];
            end
            if (r_state == cmee_pkg::S_CLEAR || r_state == cmee_pkg::S_HALVE) begin
                r_idx <= r_idx + IW'(1);
            end else begin
                r_idx <= '0;
            end
            if (prob_stat.dbl && r_entropy != ENT_MAX) begin
                r_entropy <= r_entropy + EW'(1);
            end
            if (r_state == cmee_pkg::S_WRITE) begin
                r_halve <= (new_count == CNT_LIMIT);
                if (samples_inc == WIN_LIMIT) begin
                    r_samples <= samples_inc >> 1;
                    r_entropy <= r_entropy >> 1;
                end else begin
                    r_samples <= samples_inc;
                end
            end
            if (emit_load) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
        if (in_accept) begin
            r_bit <= s_axis_tdata[0];
        end
        if (r_state == cmee_pkg::S_FETCH) begin
            r_word <= ram_rdata;
        end
        if (emit_load) begin
            r_m_tdata <= {(cmee_pkg::OUT_TDATA_W - EW - SW)'(0), r_samples, r_entropy};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_tdata;

    cmee_ram #(
        .WIDTH (RW),
        .DEPTH (DEPTH)
    ) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    cmee_prob #(
        .PROB_FRAC_BITS (PROB_FRAC_BITS)
    ) u_prob (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (prob_req),
        .o_stat  (prob_stat)
    );

    a_accept_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == cmee_pkg::S_FETCH)
        else $error("accepted word did not start a fetch");

    a_hold_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == cmee_pkg::S_EMIT && r_m_valid && !m_axis_tready)
        |=> r_state == cmee_pkg::S_EMIT && r_m_valid && $stable(r_m_tdata))
        else $error("pending output word overwritten");

    a_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_samples < WIN_LIMIT)
        else $error("sample count reached the window limit");

    a_done_in_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (prob_stat.done || prob_stat.dbl) |-> r_state == cmee_pkg::S_CALC)
        else $error("probability unit active outside calculation");

endmodule

// ----- tb/entropy_stat_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// entropy_stat_checker - result checker for the context model entropy estimator
// Watches the sample, configuration and result channels. Every accepted sample
// word is run through a bit-exact model of the context tables, the Q1.32
// probability and the two counters; the expected word is queued and compared
// field by field with the next result word that the block hands over.
// ----------------------------------------------------------------------------
module entropy_stat_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    // sample_bit
    input  logic [cmee_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // entropy_bits, samples_counted
    input  logic [cmee_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    input  logic                                i_cfg_valid,
    input  logic                                o_cfg_ready,
    input  logic [cmee_pkg::CONTEXT_BITS_W-1:0] i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);

    import cmee_pkg::*;

    localparam int TABLE_DEPTH = 1 << MAX_CONTEXT_BITS_DEF;
    localparam int PW          = PROB_FRAC_BITS_DEF + 1;

    localparam logic [PW-1:0] PROB_ONE  = {1'b1, {PROB_FRAC_BITS_DEF{1'b0}}};
    localparam logic [PW-1:0] PROB_HALF = {2'b01, {(PROB_FRAC_BITS_DEF-1){1'b0}}};
    localparam logic [ENTROPY_W-1:0] ENTROPY_MAX = {ENTROPY_W{1'b1}};

    typedef struct packed {
        logic [SAMPLE_W-1:0]  samples_counted;
        logic [ENTROPY_W-1:0] entropy_bits;
    } stat_word_t;

    stat_word_t stats_due[$];

    logic [CONTEXT_BITS_W-1:0]       context_cfg;
    logic [MAX_CONTEXT_BITS_DEF-1:0] history;
    logic                            last_bit;
    logic [15:0]                     ones_cnt  [TABLE_DEPTH];
    logic [15:0]                     zeros_cnt [TABLE_DEPTH];
    logic [PW-1:0]                   prob;
    logic [ENTROPY_W-1:0]            entropy_acc;
    logic [SAMPLE_W-1:0]             samples_acc;
    int                              fail_count = 0;

    assign o_fail_count = fail_count;

    function automatic stat_word_t absorb_sample(input logic b);
        int         width;
        int         mask;
        int         hist_next;
        logic [15:0] hit;
        logic [15:0] total;
        logic [63:0] scaled;
        logic        halve;
        stat_word_t  w;
        width = context_cfg;
        if (width < 1) begin
            width = 1;
        end
        if (width > MAX_CONTEXT_BITS_DEF) begin
            width = MAX_CONTEXT_BITS_DEF;
        end
        mask = (1 << width) - 1;
        hist_next = ((int'(history) << 1) | int'(last_bit)) & mask;
        history = hist_next[MAX_CONTEXT_BITS_DEF-1:0];
        last_bit = b;

        total = ones_cnt[history] + zeros_cnt[history];
        hit = b ? ones_cnt[history] : zeros_cnt[history];
        if (hit != 0 && total != 0) begin
            scaled = 64'(prob) * 64'(hit);
            scaled = scaled / 64'(total);
            prob = scaled[PW-1:0];
        end
        if (prob == 0) begin
            prob = 1;
        end
        while (prob <= PROB_HALF) begin
            prob = prob << 1;
            if (entropy_acc != ENTROPY_MAX) begin
                entropy_acc = entropy_acc + 1'b1;
            end
        end

        samples_acc = samples_acc + 1'b1;

        if (b) begin
            ones_cnt[history] = ones_cnt[history] + 1'b1;
            halve = (ones_cnt[history] == COUNT_LIMIT);
        end else begin
            zeros_cnt[history] = zeros_cnt[history] + 1'b1;
            halve = (zeros_cnt[history] == COUNT_LIMIT);
        end
        if (halve) begin
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                ones_cnt[i] = ones_cnt[i] >> 1;
                zeros_cnt[i] = zeros_cnt[i] >> 1;
            end
        end

        if (samples_acc == WINDOW_LIMIT) begin
            entropy_acc = entropy_acc >> 1;
            samples_acc = samples_acc >> 1;
        end

        w.entropy_bits = entropy_acc;
        w.samples_counted = samples_acc;
        return w;
    endfunction

    always @(posedge i_clk) begin : watch
        stat_word_t got;
        stat_word_t want;
        if (!i_rst_n) begin
            stats_due.delete();
            context_cfg = CONTEXT_BITS_W'(CONTEXT_BITS_RESET);
            history = '0;
            last_bit = 1'b0;
            prob = PROB_ONE;
            entropy_acc = '0;
            samples_acc = '0;
            for (int i = 0; i < TABLE_DEPTH; i++) begin
                ones_cnt[i] = '0;
                zeros_cnt[i] = '0;
            end
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                context_cfg = i_cfg_data;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata[ENTROPY_W+SAMPLE_W-1:0];
                if (stats_due.size() == 0) begin
                    $error("result word with no expectation waiting: entropy_bits %0d, %s %0d",
                           got.entropy_bits, "samples_counted", got.samples_counted);
                    fail_count++;
                end else begin
                    want = stats_due.pop_front();
                    if (got.entropy_bits !== want.entropy_bits) begin
                        $error("entropy_bits mismatch: expected %0d, actual %0d",
                               want.entropy_bits, got.entropy_bits);
                        fail_count++;
                    end
                    if (got.samples_counted !== want.samples_counted) begin
                        $error("samples_counted mismatch: expected %0d, actual %0d",
                               want.samples_counted, got.samples_counted);
                        fail_count++;
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                stats_due.push_back(absorb_sample(s_axis_tdata[0]));
            end
        end
        o_pending <= stats_due.size();
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - testbench for the context model entropy estimator
// Feeds directed and random noise bits under a range of context widths,
// including out-of-range widths and changes between runs of words, with
// random gaps and stalls on both channels. A closing run in a one-bit
// context ends the sequence.
// The checker beside the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_top;

    import cmee_pkg::*;

    typedef enum int {
        PAT_UNIFORM,
        PAT_MOSTLY_ONES,
        PAT_MOSTLY_ZEROS,
        PAT_PERIODIC
    } bit_pattern_t;

    localparam int RANDOM_WORDS = 1700;

    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_TDATA_W-1:0]     s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0]    m_axis_tdata;
    logic                      i_cfg_valid = 1'b0;
    logic                      o_cfg_ready;
    logic [CONTEXT_BITS_W-1:0] i_cfg_data = '0;
    int                        fail_count;
    int                        pending;
    bit                        sink_stalls = 1'b0;

    context_model_entropy_estimator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    entropy_stat_checker stat_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        #60000000;
        $display("[context_model_entropy_estimator] ERROR");
        $finish;
    end

    // When stalls are enabled, the result side stalls for a random number of cycles before each word.
    initial begin : result_sink
        int stall;
        @(posedge i_clk);
        forever begin
            stall = sink_stalls ? $urandom_range(0, 15) : 0;
            if (stall != 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    task automatic send_sample(input logic b, input bit gaps);
        int gap;
        gap = gaps ? $urandom_range(0, 15) : 0;
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {{(IN_TDATA_W-1){1'b0}}, b};
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_context(input logic [CONTEXT_BITS_W-1:0] width);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= width;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin : stimulus
        int           words_sent;
        int           run_len;
        int           period;
        int           bias;
        logic [15:0]  motif;
        logic         b;
        bit           src_gaps;
        bit_pattern_t pattern;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Fresh contexts under the reset width see zero counts.
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b1);
        drain_results();
        // A width of zero behaves as one.
        write_context(5'd0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b0, 1'b1);
        drain_results();
        // Widths above the maximum behave as the maximum.
        write_context(5'd31);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        drain_results();
        write_context(5'd17);
        send_sample(1'b1, 1'b1);
        send_sample(1'b1, 1'b0);
        drain_results();
        write_context(5'd1);
        send_sample(1'b0, 1'b0);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);
        send_sample(1'b0, 1'b0);
        drain_results();
        write_context(5'd16);
        send_sample(1'b1, 1'b0);
        send_sample(1'b0, 1'b1);

        words_sent = 0;
        while (words_sent < RANDOM_WORDS) begin
            drain_results();
            case ($urandom_range(0, 4))
                0: write_context(5'd1);
                1: write_context(5'd16);
                2: write_context(CONTEXT_BITS_W'($urandom_range(0, 31)));
                default: write_context(CONTEXT_BITS_W'($urandom_range(1, 16)));
            endcase
            src_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            pattern = bit_pattern_t'($urandom_range(0, 3));
            run_len = $urandom_range(20, 150);
            period = $urandom_range(2, 16);
            bias = $urandom_range(70, 97);
            motif = 16'($urandom);
            for (int i = 0; i < run_len; i++) begin
                case (pattern)
                    PAT_MOSTLY_ONES:  b = ($urandom_range(0, 99) < bias);
                    PAT_MOSTLY_ZEROS: b = ($urandom_range(0, 99) >= bias);
                    PAT_PERIODIC:     b = motif[i % period] ^ ($urandom_range(0, 31) == 0);
                    default:          b = 1'($urandom_range(0, 1));
                endcase
                send_sample(b, src_gaps);
                words_sent++;
                if ($urandom_range(0, 199) == 0) begin
                    drain_results();
                end
            end
        end

        drain_results();
        write_context(5'd1);
        sink_stalls = 1'b1;
        repeat (40) send_sample(1'($urandom_range(0, 1)), 1'b1);

        drain_results();
        repeat (200) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("[context_model_entropy_estimator] OK");
        end else begin
            $display("[context_model_entropy_estimator] ERROR");
        end
        $finish;
    end

endmodule
